[rtl/i2cms_pkg.sv]
package i2cms_pkg;

	// Command codes as they arrive on the operation field
	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_STOP  = 2'd1,
		OP_WRITE = 2'd2,
		OP_READ  = 2'd3
	} op_t;

	// Queue depth between the front and the back
	localparam int CMD_DEPTH = 2;

	// Phase counter: a byte command runs 19 phases, start and stop run 3
	localparam int STEP_W = 5;
	localparam logic [STEP_W-1:0] BYTE_LAST_STEP = STEP_W'(18);
	localparam logic [STEP_W-1:0] LINE_LAST_STEP = STEP_W'(2);
	localparam logic [STEP_W-1:0] ACK_HIGH_STEP = STEP_W'(17);

	// One command as written by the user
	typedef struct packed {
		logic [1:0] operation;
		logic [7:0] write_data;
		logic       send_nack;
		logic [7:0] bus_data;
		logic       bus_ack;
	} in_item_t;

	// One line phase as delivered to the user
	typedef struct packed {
		logic       clock_line;
		logic       data_line;
		logic       sample_point;
		logic [7:0] read_byte;
		logic       ack_level;
		logic       last_phase;
	} out_item_t;

	// Classified command: the byte and the single bit that the operation uses
	typedef struct packed {
		op_t        op;
		logic [7:0] data;
		logic       flag;
	} cmd_t;

endpackage

[rtl/i2cms_front.sv]
module i2cms_front #(
	parameter int Depth = i2cms_pkg::CMD_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  i2cms_pkg::in_item_t  command,
	output logic                 cmd_valid,
	output i2cms_pkg::cmd_t      cmd,
	input  logic                 cmd_take
);
	import i2cms_pkg::*;

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	cmd_t              queue_q [Depth];
	logic [PtrW-1:0]   wr_ptr_q;
	logic [PtrW-1:0]   rd_ptr_q;
	logic [CntW-1:0]   count_q;
	cmd_t              cmd_in;
	logic              wr_en;
	logic              rd_en;

	// Classify: keep only the byte and the bit that the operation needs
	always_comb begin
		cmd_in.op = op_t'(command.operation);
		unique case (op_t'(command.operation))
			OP_WRITE: begin
				cmd_in.data = command.write_data;
				cmd_in.flag = command.bus_ack;
			end
			OP_READ: begin
				cmd_in.data = command.bus_data;
				cmd_in.flag = command.send_nack;
			end
			default: begin
				cmd_in.data = '0;
				cmd_in.flag = 1'b0;
			end
		endcase
	end

	assign full      = (count_q == CntW'(Depth));
	assign cmd_valid = (count_q != '0);
	assign cmd       = queue_q[rd_ptr_q];
	assign wr_en     = push && !full;
	assign rd_en     = cmd_take && cmd_valid;

	// Store the classified item
	always_ff @(posedge clk) begin
		if (wr_en) begin
			queue_q[wr_ptr_q] <= cmd_in;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[rtl/i2cms_back.sv]
module i2cms_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	input  i2cms_pkg::cmd_t      cmd,
	output logic                 cmd_take,
	output logic                 empty,
	input  logic                 pop,
	output i2cms_pkg::out_item_t phase
);
	import i2cms_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	state_t            state_q;
	op_t               op_q;
	logic [7:0]        data_q;
	logic              flag_q;
	logic [STEP_W-1:0] step_q;
	logic              out_valid_q;
	out_item_t         out_q;
	out_item_t         next_phase;
	logic              slot_free;
	logic              is_last;

	assign slot_free = !out_valid_q || pop;
	assign cmd_take  = (state_q == ST_IDLE) && cmd_valid;
	assign empty     = !out_valid_q;
	assign phase     = out_q;

	// Build the line phase for the current step
	always_comb begin
		next_phase = '0;
		is_last    = 1'b0;
		unique case (op_q)
			OP_START: begin
				is_last                = (step_q == LINE_LAST_STEP);
				next_phase.clock_line  = !is_last;
				next_phase.data_line   = (step_q == '0);
			end
			OP_STOP: begin
				is_last                = (step_q == LINE_LAST_STEP);
				next_phase.clock_line  = (step_q != '0);
				next_phase.data_line   = is_last;
			end
			OP_WRITE: begin
				is_last = (step_q == BYTE_LAST_STEP);
				if (!step_q[4]) begin
					// Bit cells, MSB first: low then high half
					next_phase.clock_line = step_q[0];
					next_phase.data_line  = data_q[~step_q[3:1]];
				end else begin
					// Release SDA and sample the acknowledge
					next_phase.clock_line   = (step_q == ACK_HIGH_STEP);
					next_phase.data_line    = 1'b1;
					next_phase.sample_point = (step_q == ACK_HIGH_STEP);
					next_phase.ack_level    = is_last ? flag_q : 1'b0;
				end
			end
			OP_READ: begin
				is_last = (step_q == BYTE_LAST_STEP);
				if (!step_q[4]) begin
					// SDA released, sample on the high half
					next_phase.clock_line   = step_q[0];
					next_phase.data_line    = 1'b1;
					next_phase.sample_point = step_q[0];
				end else begin
					// Drive ACK or NACK, then release
					next_phase.clock_line = (step_q == ACK_HIGH_STEP);
					next_phase.data_line  = is_last ? 1'b1 : flag_q;
					next_phase.read_byte  = is_last ? data_q : 8'h00;
				end
			end
			default: begin
				next_phase = '0;
			end
		endcase
		next_phase.last_phase = is_last;
	end

	// Sequencer state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			step_q      <= '0;
			op_q        <= OP_START;
			data_q      <= '0;
			flag_q      <= 1'b0;
			out_q       <= '0;
		end else begin
			if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						op_q    <= cmd.op;
						data_q  <= cmd.data;
						flag_q  <= cmd.flag;
						step_q  <= '0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (slot_free) begin
						out_q       <= next_phase;
						out_valid_q <= 1'b1;
						step_q      <= step_q + 1'b1;
						if (is_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[rtl/i2c_master_byte_sequencer.sv]
// I2C master byte sequencer.
// Commands enter on the push/full queue port: start, stop, write byte or
// read byte, with the write byte, the read ACK/NACK choice and the levels
// the slave presents on SDA. Each command comes out as a run of SCL/SDA
// line phases on the empty/pop queue port, one item per phase: 3 phases
// for start and stop, 19 for a byte write or read. The last phase of a
// command carries last_phase, the sampled byte of a read and the sampled
// acknowledge of a write.
// A command pushed into an idle block is written into the command queue,
// loaded into the sequencer and then registered as its first phase in the
// output register. The phase sequencer emits one phase per cycle while pop
// stays high, and passes through its idle state to load each command. A
// two-entry command queue keeps accepting commands while the sequencer runs.
// When pop is low the sequencer holds its current phase in the output
// register and stops; the command queue fills and full rises.
// Reset empties the command queue and the output register and returns the
// sequencer to idle; no line state is kept between commands.
module i2c_master_byte_sequencer #(
	parameter int CmdDepth = i2cms_pkg::CMD_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  i2cms_pkg::in_item_t  command,
	output logic                 empty,
	input  logic                 pop,
	output i2cms_pkg::out_item_t phase
);
	import i2cms_pkg::*;

	logic cmd_valid;
	logic cmd_take;
	cmd_t cmd;

	i2cms_front #(
		.Depth(CmdDepth)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.command  (command),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.cmd_take (cmd_take)
	);

	i2cms_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.cmd_take (cmd_take),
		.empty    (empty),
		.pop      (pop),
		.phase    (phase)
	);

	// The master samples SDA only while SCL is high
	a_sample_high: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && phase.sample_point) |-> phase.clock_line)
		else $error("sample point with SCL low");

	// Result fields appear only on the final phase
	a_result_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (phase.read_byte != 8'h00 || phase.ack_level)) |-> phase.last_phase)
		else $error("result field set before the final phase");

	// The sequencer takes a command only when the queue holds one
	a_take_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_take |-> cmd_valid)
		else $error("command taken from an empty queue");

endmodule

[bench/tb.sv]
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import i2cms_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_COMMANDS = 380;
	localparam int DRAIN_CYCLES = 30;

	typedef enum {POP_ALWAYS, POP_COIN, POP_SPARSE, POP_HOLD} pop_style_t;

	// Expands accepted commands into line phases and checks popped phases in order
	class line_phase_tracker;
		out_item_t awaited_phases[$];
		int mismatches;
		int phase_index;

		task flag_mismatch(string msg);
			$display("mismatch at phase %0d: %s", phase_index, msg);
			mismatches++;
		endtask

		function void add_phase(logic scl, logic sda, logic smp, logic [7:0] rbyte,
			logic ack, logic last);
			out_item_t p;
			p.clock_line = scl;
			p.data_line = sda;
			p.sample_point = smp;
			p.read_byte = rbyte;
			p.ack_level = ack;
			p.last_phase = last;
			awaited_phases.push_back(p);
		endfunction

		function void note_command(in_item_t c);
			case (op_t'(c.operation))
				OP_START: begin
					add_phase(1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0);
					add_phase(1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
					add_phase(1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b1);
				end
				OP_STOP: begin
					add_phase(1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
					add_phase(1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
					add_phase(1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b1);
				end
				OP_WRITE: begin
					// shift the byte out MSB first, then release SDA for the ack
					for (int i = 7; i >= 0; i--) begin
						add_phase(1'b0, c.write_data[i], 1'b0, 8'h00, 1'b0, 1'b0);
						add_phase(1'b1, c.write_data[i], 1'b0, 8'h00, 1'b0, 1'b0);
					end
					add_phase(1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0);
					add_phase(1'b1, 1'b1, 1'b1, 8'h00, 1'b0, 1'b0);
					add_phase(1'b0, 1'b1, 1'b0, 8'h00, c.bus_ack, 1'b1);
				end
				default: begin
					// read: SDA released while sampling, then drive ACK or NACK
					for (int i = 0; i < 8; i++) begin
						add_phase(1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0);
						add_phase(1'b1, 1'b1, 1'b1, 8'h00, 1'b0, 1'b0);
					end
					add_phase(1'b0, c.send_nack, 1'b0, 8'h00, 1'b0, 1'b0);
					add_phase(1'b1, c.send_nack, 1'b0, 8'h00, 1'b0, 1'b0);
					add_phase(1'b0, 1'b1, 1'b0, c.bus_data, 1'b0, 1'b1);
				end
			endcase
		endfunction

		task compare_field(string name, int got, int want);
			if (got != want)
				flag_mismatch($sformatf("%s got %0h want %0h", name, got, want));
		endtask

		task check_phase(out_item_t got);
			out_item_t want;
			if (awaited_phases.size() == 0) begin
				flag_mismatch($sformatf("unexpected phase %h", got));
			end else begin
				want = awaited_phases.pop_front();
				compare_field("clock_line", got.clock_line, want.clock_line);
				compare_field("data_line", got.data_line, want.data_line);
				compare_field("sample_point", got.sample_point, want.sample_point);
				compare_field("read_byte", got.read_byte, want.read_byte);
				compare_field("ack_level", got.ack_level, want.ack_level);
				compare_field("last_phase", got.last_phase, want.last_phase);
			end
			phase_index++;
		endtask
	endclass

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      push = 1'b0;
	logic      full;
	in_item_t  command = '0;
	logic      empty;
	logic      pop = 1'b0;
	out_item_t phase;

	line_phase_tracker tracker = new;
	bit draining = 1'b0;
	int cycle_count = 0;
	int stall_cycle = 0;
	pop_style_t pop_style = POP_ALWAYS;

	i2c_master_byte_sequencer dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.command(command),
		.empty(empty),
		.pop(pop),
		.phase(phase)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Pop phases under a changing stall pattern, check each one taken
	always @(posedge clk) begin
		logic next_pop;
		if (arst_n && pop && !empty)
			tracker.check_phase(phase);
		stall_cycle++;
		if (stall_cycle == 50) begin
			stall_cycle = 0;
			pop_style = pop_style_t'($urandom_range(POP_ALWAYS, POP_HOLD));
		end
		case (pop_style)
			POP_ALWAYS: next_pop = 1'b1;
			POP_COIN:   next_pop = 1'($urandom_range(0, 1));
			POP_SPARSE: next_pop = (stall_cycle % 4 == 0);
			default:    next_pop = (stall_cycle >= 20);
		endcase
		pop <= next_pop || draining;
	end

	function automatic in_item_t make_command(op_t op, logic [7:0] wdata, logic nack,
		logic [7:0] bdata, logic back);
		in_item_t c;
		c.operation = op;
		c.write_data = wdata;
		c.send_nack = nack;
		c.bus_data = bdata;
		c.bus_ack = back;
		return c;
	endfunction

	function automatic in_item_t random_command();
		return make_command(op_t'($urandom_range(OP_START, OP_READ)), 8'($urandom),
			1'($urandom), 8'($urandom), 1'($urandom));
	endfunction

	// Offer one item and hold it until the block takes it
	task automatic send_command(input in_item_t c);
		push <= 1'b1;
		command <= c;
		do @(posedge clk); while (full);
		tracker.note_command(c);
	endtask

	task automatic hold_off(input int n);
		push <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	initial begin
		int burst;
		int sent;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: each operation, byte extremes, both ack and nack levels
		send_command(make_command(OP_START, 8'hFF, 1'b1, 8'hFF, 1'b1));
		send_command(make_command(OP_STOP, 8'hFF, 1'b1, 8'hFF, 1'b1));
		send_command(make_command(OP_START, 8'h00, 1'b0, 8'h00, 1'b0));
		send_command(make_command(OP_WRITE, 8'h00, 1'b1, 8'hFF, 1'b0));
		send_command(make_command(OP_WRITE, 8'hFF, 1'b0, 8'h00, 1'b1));
		hold_off(5);
		send_command(make_command(OP_WRITE, 8'h80, 1'b0, 8'h00, 1'b1));
		send_command(make_command(OP_WRITE, 8'h01, 1'b1, 8'h33, 1'b0));
		send_command(make_command(OP_WRITE, 8'hA5, 1'b0, 8'h00, 1'b1));
		send_command(make_command(OP_READ, 8'hFF, 1'b0, 8'h00, 1'b1));
		hold_off(3);
		send_command(make_command(OP_READ, 8'h00, 1'b1, 8'hFF, 1'b0));
		send_command(make_command(OP_READ, 8'h00, 1'b1, 8'h5A, 1'b1));
		send_command(make_command(OP_READ, 8'hC3, 1'b0, 8'hA5, 1'b0));
		send_command(make_command(OP_STOP, 8'h00, 1'b0, 8'h00, 1'b0));
		hold_off(10);

		// random: bursts of random length, gaps of random size between them
		sent = 0;
		while (sent < RANDOM_COMMANDS) begin
			burst = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
			repeat (burst) begin
				send_command(random_command());
				sent++;
			end
			if ($urandom_range(0, 3) != 0)
				hold_off($urandom_range(1, 25));
		end
		push <= 1'b0;

		// drain what is still owed, then watch for stray phases
		while (tracker.awaited_phases.size() != 0) @(posedge clk);
		draining = 1'b1;
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.awaited_phases.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

[i2c_master_byte_sequencer.f]
rtl/i2cms_pkg.sv
rtl/i2cms_front.sv
rtl/i2cms_back.sv
rtl/i2c_master_byte_sequencer.sv
bench/tb.sv
